FILE: hw/rtl/zce_pkg.sv
package zce_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int MIN_DIM    = 3;

	// column and row counters, line store address
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int DIM_W = 11;
	localparam int THR_W = 16;
	localparam int CFG_DATA_W = 16;

	// one line store word holds the row two above (upper half) and the row above
	localparam int WORD_W = 2 * PIXEL_BITS;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;

	typedef enum logic [1:0] {
		CFG_WIDTH     = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

	// control that travels with an item from the address stage to the judge stage
	typedef struct packed {
		logic             has_result;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] addr;
	} stage_ctl_t;

endpackage

FILE: hw/rtl/zce_if.sv
interface zce_pix_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [zce_pkg::PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

interface zce_res_if;
	logic                           valid;
	logic                           ready;
	logic [zce_pkg::ROW_W-1:0]      out_row;
	logic [zce_pkg::COL_W-1:0]      out_col;
	logic                           is_edge;
	logic                           frame_done;

	modport source (output valid, output out_row, output out_col, output is_edge,
		output frame_done, input ready);
	modport sink   (input valid, input out_row, input out_col, input is_edge,
		input frame_done, output ready);
endinterface

FILE: hw/rtl/zero_crossing_edge_detector.sv
// zero crossing edge detector over a 3x3 window
// pix: sink channel of signed Q8.8 filtered pixels in raster order, one item per pixel.
// res: source channel, one item per interior pixel with its row, column, edge flag and
//   a frame_done mark on the last interior pixel of the frame; border pixels give none.
// config: cfg_we/cfg_index/cfg_data write image_width, image_height and edge_threshold;
//   geometry outside 3..1024 is clamped.
// throughput: one pixel per cycle while pix.ready is high. Each item passes the address
//   stage (line store read issued), then the judge stage; its result is then presented
//   on res from an output register that holds it.
// the two line stores share one 1024 x 32 memory with one read and one write port;
//   reads and writes of back-to-back items always hit different columns.
// reset: counters and window clear, registers return to 640 x 480, threshold 0;
//   a sweep then zeroes all 1024 line memory entries with pix.ready low
//   (configuration writes are taken during the sweep).
// stall: while res is held the output register keeps its item, the judge stage
//   keeps one more, and pix.ready drops only when both are full.
module zero_crossing_edge_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [zce_pkg::CFG_DATA_W-1:0]  cfg_data,
	zce_pix_if.sink                         pix,
	zce_res_if.source                       res
);
	import zce_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [THR_W-1:0] thr_q;
	logic [DIM_W-1:0] eff_w, eff_h;

	logic [COL_W-1:0] col_q, col_cur;
	logic [ROW_W-1:0] row_q, row_cur;
	logic [DIM_W-1:0] col_inc, row_inc;
	logic             col_wrap;

	logic             accept, s1_go, cleared;
	logic             s1_v;
	stage_ctl_t       ctl_s1, ctl_s0;
	pixel_t           bot_s1;

	logic [WORD_W-1:0] rd_word;
	pixel_t            top, mid;
	logic              edge_flag;

	logic             out_v_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             is_edge_q, frame_done_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:     width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:    height_q <= cfg_data[DIM_W-1:0];
				CFG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < DIM_W'(MIN_DIM))        eff_w = DIM_W'(MIN_DIM);
		else if (width_q > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
		else                                  eff_w = width_q;
		if (height_q < DIM_W'(MIN_DIM))        eff_h = DIM_W'(MIN_DIM);
		else if (height_q > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
		else                                    eff_h = height_q;
	end

	// address stage: position of the incoming pixel
	assign col_cur  = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
	assign row_cur  = ({1'b0, row_q} >= eff_h) ? '0 : row_q;
	assign col_inc  = {1'b0, col_cur} + 1'b1;
	assign row_inc  = {1'b0, row_cur} + 1'b1;
	assign col_wrap = (col_inc >= eff_w);

	always_comb begin
		ctl_s0.has_result = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
		ctl_s0.last       = ({1'b0, row_cur} == eff_h - 1'b1)
			&& ({1'b0, col_cur} == eff_w - 1'b1);
		ctl_s0.row        = row_cur - 1'b1;
		ctl_s0.col        = col_cur - 1'b1;
		ctl_s0.addr       = col_cur;
	end

	// judge stage moves unless it holds a result that the output register cannot take
	assign s1_go     = !s1_v || !ctl_s1.has_result || !out_v_q || res.ready;
	assign pix.ready = cleared && s1_go;
	assign accept    = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_go) begin
			s1_v <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_s0;
			bot_s1 <= pix.pixel_value;
		end
	end

	zce_line_mem u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (rd_word),
		.wr_en   (s1_v && s1_go),
		.wr_addr (ctl_s1.addr),
		.wr_data ({mid, bot_s1}),
		.cleared (cleared)
	);

	assign top = rd_word[WORD_W-1:PIXEL_BITS];
	assign mid = rd_word[PIXEL_BITS-1:0];

	zce_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (s1_v && s1_go),
		.top       (top),
		.mid       (mid),
		.bot       (bot_s1),
		.threshold (thr_q),
		.is_edge   (edge_flag)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_v && s1_go && ctl_s1.has_result) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v && s1_go && ctl_s1.has_result) begin
			out_row_q    <= ctl_s1.row;
			out_col_q    <= ctl_s1.col;
			is_edge_q    <= edge_flag;
			frame_done_q <= ctl_s1.last;
		end
	end

	assign res.valid      = out_v_q;
	assign res.out_row    = out_row_q;
	assign res.out_col    = out_col_q;
	assign res.is_edge    = is_edge_q;
	assign res.frame_done = frame_done_q;

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ({1'b0, col_cur} < eff_w) && ({1'b0, row_cur} < eff_h))
		else $error("pixel position outside the frame");
	a_result_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_row_q != '0) && (out_col_q != '0))
		else $error("result for a border pixel");
	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !s1_go) |=> s1_v && $stable(ctl_s1) && $stable(rd_word))
		else $error("judge stage lost its item while stalled");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && s1_go && ctl_s1.has_result) |-> (!out_v_q || res.ready))
		else $error("output register overwritten");

endmodule

FILE: hw/rtl/zce_line_mem.sv
module zce_line_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [zce_pkg::COL_W-1:0]  rd_addr,
	output logic [zce_pkg::WORD_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [zce_pkg::COL_W-1:0]  wr_addr,
	input  logic [zce_pkg::WORD_W-1:0] wr_data,
	output logic                       cleared
);
	import zce_pkg::*;

	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [COL_W:0]    clr_q;
	logic [WORD_W-1:0] rd_q;

	assign cleared = clr_q[COL_W];
	assign rd_data = rd_q;

	// zeroing sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[COL_W]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[COL_W]) begin
			mem[clr_q[COL_W-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!cleared |-> !rd_en) else $error("line store read during sweep");
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write collide on one line store entry");
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!cleared |-> !wr_en) else $error("line store write during sweep");

endmodule

FILE: hw/rtl/zce_judge.sv
module zce_judge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  zce_pkg::pixel_t           top,
	input  zce_pkg::pixel_t           mid,
	input  zce_pkg::pixel_t           bot,
	input  logic [zce_pkg::THR_W-1:0] threshold,
	output logic                      is_edge
);
	import zce_pkg::*;

	// win_q[0..2]: top/mid/bot two columns back, win_q[3..5]: one column back
	pixel_t win_q [6];

	function automatic logic crosses(input pixel_t p, input pixel_t q,
		input logic [THR_W-1:0] thr);
		logic             opposite;
		logic [PIXEL_BITS:0] d;
		logic [PIXEL_BITS:0] mag;
		opposite = (p[PIXEL_BITS-1] && !q[PIXEL_BITS-1] && (q != '0))
			|| (q[PIXEL_BITS-1] && !p[PIXEL_BITS-1] && (p != '0));
		d   = {p[PIXEL_BITS-1], p} - {q[PIXEL_BITS-1], q};
		mag = d[PIXEL_BITS] ? (~d + 1'b1) : d;
		return opposite && (mag > {1'b0, thr});
	endfunction

	assign is_edge = crosses(win_q[0], bot, threshold)
		|| crosses(win_q[1], mid, threshold)
		|| crosses(win_q[2], top, threshold)
		|| crosses(win_q[5], win_q[3], threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	a_shift_moves_column: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> (win_q[3] == $past(top)) && (win_q[0] == $past(win_q[3])))
		else $error("window did not shift by one column");

endmodule
